// ===== design/qis_pkg.sv =====
// ----------------------------------------------------------------------------
// qis_pkg: shared types and codes of the qualified identifier splitter
// Result kinds, error codes, parse phases and the structs passed between
// the parse step, the result queue and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package qis_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Result kinds
  localparam logic [1:0] KIND_CHAR     = 2'd0;
  localparam logic [1:0] KIND_END_PART = 2'd1;
  localparam logic [1:0] KIND_ACCEPT   = 2'd2;
  localparam logic [1:0] KIND_ERROR    = 2'd3;

  // Error codes
  localparam logic [2:0] ERR_NONE         = 3'd0;
  localparam logic [2:0] ERR_UNCLOSED     = 3'd1;
  localparam logic [2:0] ERR_EMPTY_QUOTED = 3'd2;
  localparam logic [2:0] ERR_BEFORE_DOT   = 3'd3;
  localparam logic [2:0] ERR_AFTER_DOT    = 3'd4;
  localparam logic [2:0] ERR_INVALID      = 3'd5;

  // Parse phases
  localparam logic [2:0] PH_EXPECT     = 3'd0;
  localparam logic [2:0] PH_UNQUOTED   = 3'd1;
  localparam logic [2:0] PH_QUOTED     = 3'd2;
  localparam logic [2:0] PH_QUOTE_SEEN = 3'd3;
  localparam logic [2:0] PH_AFTER      = 3'd4;
  localparam logic [2:0] PH_DONE       = 3'd5;

  // Characters
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_UNDER  = 8'h5F;

  typedef struct packed {
    logic [2:0] phase;
    logic       dot_seen;
    logic       quoted_nonempty;
  } qis_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] ch;
    logic [2:0] err;
  } qis_result_t;

  typedef struct packed {
    logic [1:0]  count;
    qis_result_t res0;
    qis_result_t res1;
  } qis_step_t;

endpackage

`default_nettype wire

// ===== design/qualified_identifier_splitter_unit.sv =====
// ----------------------------------------------------------------------------
// qualified_identifier_splitter_unit: dotted SQL name splitter
// Splits a byte stream holding a qualified name into part characters,
// end-of-part marks and a final accept or error item.
// ----------------------------------------------------------------------------
//
//  Channel   Dir   Signals                          Contents
//  s_*       in    s_tvalid s_tready s_tdata s_tlast  text byte, end of text
//  m_*       out   m_tvalid m_tready m_tdata m_tuser  char, error code, kind
//  cfg_*     in    cfg_we cfg_wdata                   strict mode bit
//
//  One input item per cycle is accepted while the result queue has room;
//  an item's first result passes the input register, then the result queue.
//  An item may yield two results, which leave one at a time; the four-entry
//  result queue absorbs them and input stalls only while fewer than two
//  entries are free. Synchronous reset returns the parse to its start, the
//  strict bit to zero and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module qualified_identifier_splitter_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
  input  wire logic        s_tlast,   // end_of_text
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [7:0] part_char, [10:8] error_code, rest zero
  output logic [1:0]       m_tuser,   // [1:0] result_kind
  input  wire logic        cfg_we,
  input  wire logic        cfg_wdata
);

  logic                 strict_mode;
  logic                 in_valid;
  logic [7:0]           in_byte;
  logic                 in_end;
  logic                 room;
  logic                 process;
  qis_pkg::qis_state_t  state;
  qis_pkg::qis_state_t  state_next;
  qis_pkg::qis_step_t   step;
  qis_pkg::qis_result_t out_result;

  assign process  = in_valid && room;
  assign s_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      strict_mode <= 1'b0;
    end else if (cfg_we) begin
      strict_mode <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (process) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_end  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '{qis_pkg::PH_EXPECT, 1'b0, 1'b0};
    end else if (process) begin
      state <= state_next;
    end
  end

  qis_step u_step (
    .state       (state),
    .text_byte   (in_byte),
    .end_of_text (in_end),
    .strict_mode (strict_mode),
    .state_next  (state_next),
    .step        (step)
  );

  qis_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (step),
    .push_en    (process),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (out_result)
  );

  assign m_tuser = out_result.kind;
  assign m_tdata = {5'd0, out_result.err, out_result.ch};

  // An end marker always leaves the parse at its start.
  a_end_restarts: assert property (@(posedge clk) disable iff (rst)
    process && in_end |=> state.phase == qis_pkg::PH_EXPECT && !state.dot_seen
      && !state.quoted_nonempty)
    else $error("end of text did not restart the parse");

  // A finished parse stays finished until the end marker.
  a_done_holds: assert property (@(posedge clk) disable iff (rst)
    process && !in_end && state.phase == qis_pkg::PH_DONE |=>
      state.phase == qis_pkg::PH_DONE)
    else $error("finished parse left without end marker");

  // Two results only come as an end of part followed by the byte after it.
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    process && step.count == 2'd2 |->
      step.res0.kind == qis_pkg::KIND_END_PART &&
      (step.res1.kind == qis_pkg::KIND_ACCEPT || step.res1.kind == qis_pkg::KIND_ERROR))
    else $error("bad result pair");

  // A held item waiting for queue room is not dropped.
  a_hold_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !room |=> in_valid && $stable(in_byte) && $stable(in_end))
    else $error("stalled item lost");

endmodule

`default_nettype wire

// ===== design/qis_step.sv =====
// ----------------------------------------------------------------------------
// qis_step: one parse step
// Decides one byte against the parse state and gives the next state and
// up to two results.
// ----------------------------------------------------------------------------
`default_nettype none

module qis_step (
  input  wire qis_pkg::qis_state_t state,
  input  wire logic [7:0]          text_byte,
  input  wire logic                end_of_text,
  input  wire logic                strict_mode,
  output qis_pkg::qis_state_t      state_next,
  output qis_pkg::qis_step_t       step
);

  function automatic logic is_space(input logic [7:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0C;
  endfunction

  function automatic logic is_upper(input logic [7:0] c);
    return c >= 8'h41 && c <= 8'h5A;
  endfunction

  function automatic logic is_start(input logic [7:0] c);
    return c == qis_pkg::CH_UNDER || (c >= 8'h61 && c <= 8'h7A) || is_upper(c) || c[7];
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || c == qis_pkg::CH_DOLLAR || is_start(c);
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return is_upper(c) ? (c | 8'h20) : c;
  endfunction

  qis_pkg::qis_result_t res [2];
  logic [1:0]           cnt;
  logic                 do_after;
  logic [2:0]           miss_code;

  always_comb begin
    state_next = state;
    res[0]     = '0;
    res[1]     = '0;
    cnt        = 2'd0;
    do_after   = 1'b0;
    miss_code  = state.dot_seen ? qis_pkg::ERR_AFTER_DOT : qis_pkg::ERR_INVALID;

    unique case (state.phase)
      qis_pkg::PH_EXPECT: begin
        if (end_of_text) begin
          res[0]     = '{qis_pkg::KIND_ERROR, 8'd0, miss_code};
          cnt        = 2'd1;
          state_next = '{qis_pkg::PH_EXPECT, 1'b0, 1'b0};
        end else if (is_space(text_byte)) begin
          cnt = 2'd0;
        end else if (text_byte == qis_pkg::CH_QUOTE) begin
          state_next.quoted_nonempty = 1'b0;
          state_next.phase           = qis_pkg::PH_QUOTED;
        end else if (is_start(text_byte)) begin
          state_next.phase = qis_pkg::PH_UNQUOTED;
          res[0]           = '{qis_pkg::KIND_CHAR, to_lower(text_byte), qis_pkg::ERR_NONE};
          cnt              = 2'd1;
        end else if (text_byte == qis_pkg::CH_DOT) begin
          res[0]           = '{qis_pkg::KIND_ERROR, 8'd0, qis_pkg::ERR_BEFORE_DOT};
          cnt              = 2'd1;
          state_next.phase = qis_pkg::PH_DONE;
        end else begin
          res[0]           = '{qis_pkg::KIND_ERROR, 8'd0, miss_code};
          cnt              = 2'd1;
          state_next.phase = qis_pkg::PH_DONE;
        end
      end
      qis_pkg::PH_UNQUOTED: begin
        if (!end_of_text && is_cont(text_byte)) begin
          res[0] = '{qis_pkg::KIND_CHAR, to_lower(text_byte), qis_pkg::ERR_NONE};
          cnt    = 2'd1;
        end else begin
          res[0]   = '{qis_pkg::KIND_END_PART, 8'd0, qis_pkg::ERR_NONE};
          cnt      = 2'd1;
          do_after = 1'b1;
        end
      end
      qis_pkg::PH_QUOTED: begin
        if (end_of_text) begin
          res[0]     = '{qis_pkg::KIND_ERROR, 8'd0, qis_pkg::ERR_UNCLOSED};
          cnt        = 2'd1;
          state_next = '{qis_pkg::PH_EXPECT, 1'b0, 1'b0};
        end else if (text_byte == qis_pkg::CH_QUOTE) begin
          state_next.phase = qis_pkg::PH_QUOTE_SEEN;
        end else begin
          state_next.quoted_nonempty = 1'b1;
          res[0] = '{qis_pkg::KIND_CHAR, text_byte, qis_pkg::ERR_NONE};
          cnt    = 2'd1;
        end
      end
      qis_pkg::PH_QUOTE_SEEN: begin
        if (!end_of_text && text_byte == qis_pkg::CH_QUOTE) begin
          state_next.quoted_nonempty = 1'b1;
          state_next.phase           = qis_pkg::PH_QUOTED;
          res[0] = '{qis_pkg::KIND_CHAR, qis_pkg::CH_QUOTE, qis_pkg::ERR_NONE};
          cnt    = 2'd1;
        end else if (!state.quoted_nonempty) begin
          res[0] = '{qis_pkg::KIND_ERROR, 8'd0, qis_pkg::ERR_EMPTY_QUOTED};
          cnt    = 2'd1;
          if (end_of_text) begin
            state_next = '{qis_pkg::PH_EXPECT, 1'b0, 1'b0};
          end else begin
            state_next.phase = qis_pkg::PH_DONE;
          end
        end else begin
          res[0]   = '{qis_pkg::KIND_END_PART, 8'd0, qis_pkg::ERR_NONE};
          cnt      = 2'd1;
          do_after = 1'b1;
        end
      end
      qis_pkg::PH_AFTER: begin
        do_after = 1'b1;
      end
      default: begin
        // Finished parse: drop bytes until the end marker restarts it.
        if (end_of_text) begin
          state_next = '{qis_pkg::PH_EXPECT, 1'b0, 1'b0};
        end else begin
          state_next.phase = qis_pkg::PH_DONE;
        end
      end
    endcase

    // Byte that follows a completed part; it may add a second result.
    if (do_after) begin
      state_next.phase = qis_pkg::PH_AFTER;
      if (end_of_text) begin
        res[cnt[0]] = '{qis_pkg::KIND_ACCEPT, 8'd0, qis_pkg::ERR_NONE};
        cnt         = cnt + 2'd1;
        state_next  = '{qis_pkg::PH_EXPECT, 1'b0, 1'b0};
      end else if (is_space(text_byte)) begin
        state_next.phase = qis_pkg::PH_AFTER;
      end else if (text_byte == qis_pkg::CH_DOT) begin
        state_next.dot_seen = 1'b1;
        state_next.phase    = qis_pkg::PH_EXPECT;
      end else if (strict_mode) begin
        res[cnt[0]]      = '{qis_pkg::KIND_ERROR, 8'd0, qis_pkg::ERR_INVALID};
        cnt              = cnt + 2'd1;
        state_next.phase = qis_pkg::PH_DONE;
      end else begin
        res[cnt[0]]      = '{qis_pkg::KIND_ACCEPT, 8'd0, qis_pkg::ERR_NONE};
        cnt              = cnt + 2'd1;
        state_next.phase = qis_pkg::PH_DONE;
      end
    end

    step.count = cnt;
    step.res0  = res[0];
    step.res1  = res[1];
  end

endmodule

`default_nettype wire

// ===== design/qis_result_queue.sv =====
// ----------------------------------------------------------------------------
// qis_result_queue: small result queue
// Takes up to two results per cycle and hands out one per cycle while the reader is ready. It
// reports room while at least two entries are free.
// ----------------------------------------------------------------------------
`default_nettype none

module qis_result_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire qis_pkg::qis_step_t   push,
  input  wire logic                 push_en,
  output logic                      room,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output qis_pkg::qis_result_t      out_result
);

  localparam int unsigned AW = qis_pkg::QUEUE_AW;

  qis_pkg::qis_result_t   mem [qis_pkg::QUEUE_DEPTH];
  logic [AW-1:0]          wr_ptr;
  logic [AW-1:0]          rd_ptr;
  logic [AW:0]            level;
  logic [AW:0]            level_next;
  logic [1:0]             n_push;
  logic                   pop;

  assign n_push     = push_en ? push.count : 2'd0;
  assign out_valid  = level != '0;
  assign pop        = out_valid && out_ready;
  assign room       = level <= (AW + 1)'(qis_pkg::QUEUE_DEPTH - 2);
  assign out_result = mem[rd_ptr];
  assign level_next = level + (AW + 1)'(n_push) - (AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + AW'(n_push);
      rd_ptr <= rd_ptr + AW'(pop);
      level  <= level_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) begin
      mem[wr_ptr] <= push.res0;
    end
    if (n_push == 2'd2) begin
      mem[wr_ptr + AW'(1)] <= push.res1;
    end
  end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for qualified_identifier_splitter_unit
// Feeds dotted names, mutated names and raw byte noise through the stream
// input under random gaps and back-pressure. A scoreboard predicts the part
// characters, end-of-part marks and final verdicts and checks each result
// as it arrives. The run covers both strict-mode settings.
// ----------------------------------------------------------------------------
module tb;
  import qis_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } text_item_t;

  class name_scoreboard;
    bit          strict;
    logic [2:0]  phase;
    bit          dot_seen;
    bit          quoted_nonempty;
    qis_result_t expected_q[$];
    int          mismatches;
    int          checked;
    int          accepted_names;
    int          rejected_names;
    int          err_hist[8];

    function new();
      restart();
    endfunction

    function void restart();
      phase = PH_EXPECT;
      dot_seen = 1'b0;
      quoted_nonempty = 1'b0;
    endfunction

    function bit is_blank(logic [7:0] c);
      return c inside {8'h20, 8'h09, 8'h0A, 8'h0D, 8'h0C};
    endfunction

    function bit name_start(logic [7:0] c);
      return c == CH_UNDER || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c[7];
    endfunction

    function bit name_cont(logic [7:0] c);
      return (c >= "0" && c <= "9") || c == CH_DOLLAR || name_start(c);
    endfunction

    function logic [7:0] fold_case(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function void push(logic [1:0] kind, logic [7:0] ch, logic [2:0] err);
      expected_q.push_back('{kind: kind, ch: ch, err: err});
      if (kind == KIND_ACCEPT) accepted_names++;
      if (kind == KIND_ERROR) begin
        rejected_names++;
        err_hist[err]++;
      end
    endfunction

    function void abort(logic [2:0] code, logic last);
      push(KIND_ERROR, 8'h00, code);
      if (last) restart();
      else phase = PH_DONE;
    endfunction

    function void after_part(logic [7:0] c, logic last);
      phase = PH_AFTER;
      if (last) begin
        push(KIND_ACCEPT, 8'h00, ERR_NONE);
        restart();
      end else if (is_blank(c)) begin
      end else if (c == CH_DOT) begin
        dot_seen = 1'b1;
        phase = PH_EXPECT;
      end else if (strict) begin
        abort(ERR_INVALID, 1'b0);
      end else begin
        // Lenient mode: trailing text ends the parse with acceptance.
        push(KIND_ACCEPT, 8'h00, ERR_NONE);
        phase = PH_DONE;
      end
    endfunction

    // Returns 1 unless the item is a byte the block merely skips after a verdict.
    function bit note_text(logic [7:0] c, logic last);
      bit live;
      live = (phase != PH_DONE) || last;
      case (phase)
        PH_EXPECT: begin
          if (last) abort(dot_seen ? ERR_AFTER_DOT : ERR_INVALID, 1'b1);
          else if (is_blank(c)) begin
          end else if (c == CH_QUOTE) begin
            quoted_nonempty = 1'b0;
            phase = PH_QUOTED;
          end else if (name_start(c)) begin
            phase = PH_UNQUOTED;
            push(KIND_CHAR, fold_case(c), ERR_NONE);
          end else if (c == CH_DOT) abort(ERR_BEFORE_DOT, 1'b0);
          else abort(dot_seen ? ERR_AFTER_DOT : ERR_INVALID, 1'b0);
        end
        PH_UNQUOTED: begin
          if (!last && name_cont(c)) push(KIND_CHAR, fold_case(c), ERR_NONE);
          else begin
            push(KIND_END_PART, 8'h00, ERR_NONE);
            after_part(c, last);
          end
        end
        PH_QUOTED: begin
          if (last) abort(ERR_UNCLOSED, 1'b1);
          else if (c == CH_QUOTE) phase = PH_QUOTE_SEEN;
          else begin
            quoted_nonempty = 1'b1;
            push(KIND_CHAR, c, ERR_NONE);
          end
        end
        PH_QUOTE_SEEN: begin
          // A second quote is a literal quote; anything else closes the part, or rejects it if it is empty.
          if (!last && c == CH_QUOTE) begin
            quoted_nonempty = 1'b1;
            phase = PH_QUOTED;
            push(KIND_CHAR, c, ERR_NONE);
          end else if (!quoted_nonempty) abort(ERR_EMPTY_QUOTED, last);
          else begin
            push(KIND_END_PART, 8'h00, ERR_NONE);
            after_part(c, last);
          end
        end
        PH_AFTER: after_part(c, last);
        default: begin
          if (last) restart();
          else phase = PH_DONE;
        end
      endcase
      return live;
    endfunction

    task report(string msg);
      mismatches++;
      if (mismatches <= 20) $display("mismatch at result %0d: %s", checked, msg);
    endtask

    task check_result(logic [1:0] kind, logic [15:0] data);
      qis_result_t want;
      checked++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result, kind %0d data %h", kind, data));
        return;
      end
      want = expected_q.pop_front();
      if (kind !== want.kind)
        report($sformatf("kind %0d, expected %0d", kind, want.kind));
      if (data[7:0] !== want.ch)
        report($sformatf("part_char %h, expected %h", data[7:0], want.ch));
      if (data[10:8] !== want.err)
        report($sformatf("error_code %0d, expected %0d", data[10:8], want.err));
      if (data[15:11] !== 5'd0)
        report($sformatf("tdata padding %h is not zero", data[15:11]));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        cfg_we;
  logic        cfg_wdata;

  name_scoreboard sb = new;
  text_item_t     text_q[$];
  bit             steady;
  int             items_done;
  int             texts_sent;

  always #10 clk = ~clk;

  qualified_identifier_splitter_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  function automatic void put(logic [7:0] b);
    text_q.push_back('{b: b, last: 1'b0});
  endfunction

  function automatic void put_end();
    // The byte that rides with the end marker is ignored, so it is random.
    text_q.push_back('{b: 8'($urandom_range(0, 255)), last: 1'b1});
    texts_sent++;
  endfunction

  function automatic void put_str(string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
  endfunction

  function automatic logic [7:0] blank_byte();
    case ($urandom_range(0, 4))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0A;
      3: return 8'h0D;
      default: return 8'h0C;
    endcase
  endfunction

  function automatic void put_blanks();
    int n;
    n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) put(blank_byte());
  endfunction

  function automatic logic [7:0] start_byte();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range("a", "z"));
      1: return 8'($urandom_range("A", "Z"));
      2: return CH_UNDER;
      default: return 8'($urandom_range(8'h80, 8'hFF));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range("0", "9"));
      1: return CH_DOLLAR;
      default: return start_byte();
    endcase
  endfunction

  function automatic void put_part();
    int         n;
    logic [7:0] c;
    if ($urandom_range(0, 3) == 0) begin
      put(CH_QUOTE);
      n = ($urandom_range(0, 12) == 0) ? 0 : $urandom_range(1, 5);
      repeat (n) begin
        c = ($urandom_range(0, 7) == 0) ? CH_QUOTE : 8'($urandom_range(0, 255));
        put(c);
        if (c == CH_QUOTE) put(CH_QUOTE);
      end
      put(CH_QUOTE);
    end else begin
      put(start_byte());
      repeat ($urandom_range(0, 5)) put(cont_byte());
    end
  endfunction

  function automatic void compose_name();
    int parts;
    parts = $urandom_range(1, 4);
    put_blanks();
    put_part();
    for (int i = 1; i < parts; i++) begin
      put_blanks();
      put(CH_DOT);
      put_blanks();
      put_part();
    end
    put_blanks();
    if ($urandom_range(0, 5) == 0) repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
    put_end();
  endfunction

  // Mostly well-formed names; the rest are mutated names and raw noise.
  function automatic void compose_text();
    int roll;
    int base;
    int idx;
    roll = $urandom_range(0, 99);
    base = text_q.size();
    if (roll < 75) compose_name();
    else if (roll < 88) begin
      compose_name();
      idx = $urandom_range(base, text_q.size() - 2);
      if ($urandom_range(0, 1)) text_q[idx].b = 8'($urandom_range(0, 255));
      else text_q.delete(idx);
    end else begin
      repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
      put_end();
    end
  endfunction

  task automatic send_text(text_item_t it);
    while (!steady && $urandom_range(0, 99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.b;
    s_tlast  <= it.last;
    do @(posedge clk); while (!s_tready);
    if (sb.note_text(it.b, it.last)) items_done++;
  endtask

  task automatic flush_text();
    foreach (text_q[i]) send_text(text_q[i]);
    text_q.delete();
  endtask

  // Holds the input until every predicted result is out, then lets the
  // pipeline empty of items that produce nothing.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_strict(logic v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.strict = v;
  endtask

  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      m_tready <= steady || ($urandom_range(0, 99) >= 22);
    end
  end

  initial begin
    #(20 * 200_000);
    $display("FAILURE");
    $finish;
  end

  initial begin
    bit   strict_plan[6];
    int   target;
    bit   paused;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tlast   = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    steady    = 1'b0;
    paused    = 1'b0;
    strict_plan = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    write_strict(1'b0);

    // Directed: case folding, doubled quote, trailing text, empty quoted part,
    // missing parts around a dot, zero and all-ones bytes, unclosed quote.
    put_str("A.\"b\"\"c\" x");
    put_end();
    put_str("\"\"");
    put_end();
    put_str(".");
    put_end();
    put_str("a.");
    put_end();
    put(8'hFF);
    put(8'h00);
    put_end();
    put(CH_QUOTE);
    put(8'h00);
    put_end();
    flush_text();
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      write_strict(strict_plan[ph]);
      steady = (ph == 3);
      target = items_done + 100;
      while (items_done < target) begin
        if (ph == 1 && !paused && items_done >= target - 50) begin
          settle();
          paused = 1'b1;
        end
        compose_text();
        flush_text();
      end
      settle();
    end
    steady = 1'b0;

    $display("Sent %0d live items in %0d texts, strict on and off; %0d results checked.",
             items_done, texts_sent, sb.checked);
    $display("Errors: unclosed %0d, empty %0d, before dot %0d, after dot %0d, invalid %0d.",
             sb.err_hist[ERR_UNCLOSED], sb.err_hist[ERR_EMPTY_QUOTED],
             sb.err_hist[ERR_BEFORE_DOT], sb.err_hist[ERR_AFTER_DOT],
             sb.err_hist[ERR_INVALID]);
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
